FILE: design/slpl_pkg.sv
// shared types, constants and helpers for the slot pool linked list unit
// no dependencies; imported by every module of the block
package slpl_pkg;

   localparam int NUM_SLOTS = 128;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int ID_W      = $clog2(NUM_SLOTS + 1);
   localparam int OP_W      = 2;
   localparam int ST_W      = 2;

   typedef logic [ID_W-1:0]   id_type;
   typedef logic [SLOT_W-1:0] addr_type;

   localparam id_type SLOT_NONE = ID_W'(NUM_SLOTS);

   typedef enum logic [OP_W-1:0] {
      OP_INIT   = 2'd0,
      OP_ALLOC  = 2'd1,
      OP_REMOVE = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_PROTECTED = 2'd2,
      ST_NOT_USED  = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic eval;
      logic wr2;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_wr2;
   } stat_type;

   // prev link of an entry not written since init: free chain 1..N-1
   function automatic id_type default_prev(addr_type addr);
      id_type res;
      if (addr == '0 || addr == SLOT_W'(NUM_SLOTS - 1)) begin
         res = SLOT_NONE;
      end else begin
         res = id_type'(addr) + id_type'(1);
      end
      return res;
   endfunction

endpackage

FILE: design/slot_pool_linked_list_unit.sv
// slot pool with lifo free list and doubly linked active list; top level
// init, query and refused ops strobe the result after the evaluate state; a successful
//   allocate or remove passes a second write state first (one registered link-memory read,
//   one or two writes per memory), set by the single write port per link memory
// reset (synchronous) leaves the pool as after init; a new op is taken only when busy is low
// the receiver cannot stall: each result is shown for one cycle under rsp_strobe
// depends on slpl_pkg, slpl_ctrl, slpl_dpath
module slot_pool_linked_list_unit (
   input  logic                          clock,
   input  logic                          reset,
   // command side
   input  logic                          start,
   output logic                          busy,
   input  logic [slpl_pkg::OP_W-1:0]     req_opcode,
   input  logic [slpl_pkg::SLOT_W-1:0]   req_slot_index,
   // result side
   output logic                          rsp_strobe,
   output logic [slpl_pkg::ID_W-1:0]     rsp_result_slot,
   output logic [slpl_pkg::ST_W-1:0]     rsp_status,
   output logic [slpl_pkg::ID_W-1:0]     rsp_used_count
);
   import slpl_pkg::*;

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: idle, evaluate with read data, optional second write
   slpl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // link memories carry per-entry valid bits so init clears only the valid bits
   slpl_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_slot_index  (req_slot_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_slot (rsp_result_slot),
      .rsp_status      (rsp_status),
      .rsp_used_count  (rsp_used_count)
   );

endmodule

FILE: design/slpl_ctrl.sv
// sequencer for the slot pool: accept, evaluate, optional second write
// depends on slpl_pkg for the command and status structs
module slpl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  slpl_pkg::stat_type stat,
   output slpl_pkg::cmd_type  cmd,
   output logic               busy
);
   import slpl_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EVAL = 3'b010,
      S_WR2  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = stat.need_wr2 ? S_WR2 : S_IDLE;
         end
         S_WR2: begin
            cmd.wr2  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: design/slpl_dpath.sv
// datapath of the slot pool: link memories, in-use bits, list pointers, result register
// depends on slpl_pkg; driven by slpl_ctrl through cmd_type
module slpl_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  slpl_pkg::cmd_type             cmd,
   output slpl_pkg::stat_type            stat,
   input  logic [slpl_pkg::OP_W-1:0]     req_opcode,
   input  logic [slpl_pkg::SLOT_W-1:0]   req_slot_index,
   output logic                          rsp_strobe,
   output logic [slpl_pkg::ID_W-1:0]     rsp_result_slot,
   output logic [slpl_pkg::ST_W-1:0]     rsp_status,
   output logic [slpl_pkg::ID_W-1:0]     rsp_used_count
);
   import slpl_pkg::*;

   // link memories
   id_type next_mem [NUM_SLOTS];
   id_type prev_mem [NUM_SLOTS];

   logic [NUM_SLOTS-1:0] next_vld_ff, next_vld_in;
   logic [NUM_SLOTS-1:0] prev_vld_ff, prev_vld_in;
   logic [NUM_SLOTS-1:0] in_use_ff, in_use_in;

   id_type free_head_ff, free_head_in;
   id_type tail_ff, tail_in;
   id_type count_ff, count_in;

   op_type   op_ff;
   addr_type idx_ff;
   addr_type rd_addr_ff, rd_addr_in;
   id_type   rd_next_raw_ff, rd_prev_raw_ff;
   logic     rd_nvld_ff, rd_pvld_ff;

   id_type link_p_ff, link_p_in;
   id_type link_n_ff, link_n_in;
   id_type work_slot_ff, work_slot_in;
   logic   was_tail_ff, was_tail_in;

   logic       rsp_strobe_ff;
   id_type     rsp_slot_ff, rsp_slot_in;
   status_type rsp_status_ff, rsp_status_in;
   id_type     rsp_count_ff, rsp_count_in;
   logic       rsp_load;

   logic     nwe, pwe;
   addr_type nwr_addr, pwr_addr;
   id_type   nwr_data, pwr_data;

   id_type rd_next, rd_prev;
   logic   cur_used;

   assign rd_addr_in = (op_type'(req_opcode) == OP_ALLOC) ? free_head_ff[SLOT_W-1:0]
                                                           : req_slot_index;
   assign rd_next  = rd_nvld_ff ? rd_next_raw_ff : SLOT_NONE;
   assign rd_prev  = rd_pvld_ff ? rd_prev_raw_ff : default_prev(rd_addr_ff);
   assign cur_used = in_use_ff[idx_ff];

   assign stat.need_wr2 = ((op_ff == OP_ALLOC) && (free_head_ff != SLOT_NONE)) ||
                          ((op_ff == OP_REMOVE) && (idx_ff != '0) && cur_used);

   always_comb begin
      next_vld_in   = next_vld_ff;
      prev_vld_in   = prev_vld_ff;
      in_use_in     = in_use_ff;
      free_head_in  = free_head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      link_p_in     = link_p_ff;
      link_n_in     = link_n_ff;
      work_slot_in  = work_slot_ff;
      was_tail_in   = was_tail_ff;
      rsp_load      = 1'b0;
      rsp_slot_in   = SLOT_NONE;
      rsp_status_in = ST_OK;
      rsp_count_in  = count_ff;
      nwe           = 1'b0;
      pwe           = 1'b0;
      nwr_addr      = '0;
      pwr_addr      = '0;
      nwr_data      = SLOT_NONE;
      pwr_data      = SLOT_NONE;

      if (cmd.eval) begin
         case (op_ff)
            OP_INIT: begin
               next_vld_in   = '0;
               prev_vld_in   = '0;
               in_use_in     = NUM_SLOTS'(1);
               free_head_in  = id_type'(1);
               tail_in       = '0;
               count_in      = id_type'(1);
               rsp_load      = 1'b1;
               rsp_slot_in   = '0;
               rsp_count_in  = id_type'(1);
            end
            OP_ALLOC: begin
               if (free_head_ff == SLOT_NONE) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_FULL;
               end else begin
                  // new slot becomes the tail: no successor, old tail before it
                  nwe          = 1'b1;
                  nwr_addr     = free_head_ff[SLOT_W-1:0];
                  nwr_data     = SLOT_NONE;
                  pwe          = 1'b1;
                  pwr_addr     = free_head_ff[SLOT_W-1:0];
                  pwr_data     = tail_ff;
                  work_slot_in = free_head_ff;
                  free_head_in = rd_prev;
                  count_in     = count_ff + id_type'(1);
               end
            end
            OP_REMOVE: begin
               if (idx_ff == '0) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_PROTECTED;
               end else if (!cur_used) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_NOT_USED;
               end else begin
                  // bypass the slot forward, push it on the free list
                  if (rd_prev != SLOT_NONE) begin
                     nwe      = 1'b1;
                     nwr_addr = rd_prev[SLOT_W-1:0];
                     nwr_data = rd_next;
                  end
                  pwe              = 1'b1;
                  pwr_addr         = idx_ff;
                  pwr_data         = free_head_ff;
                  free_head_in     = id_type'(idx_ff);
                  in_use_in[idx_ff] = 1'b0;
                  count_in         = count_ff - id_type'(1);
                  was_tail_in      = (id_type'(idx_ff) == tail_ff);
                  if (id_type'(idx_ff) == tail_ff) begin
                     tail_in = rd_prev;
                  end
                  link_p_in = rd_prev;
                  link_n_in = rd_next;
               end
            end
            default: begin
               // successor query
               rsp_load      = 1'b1;
               rsp_slot_in   = rd_next;
               rsp_status_in = cur_used ? ST_OK : ST_NOT_USED;
            end
         endcase
      end

      if (cmd.wr2) begin
         rsp_load = 1'b1;
         if (op_ff == OP_ALLOC) begin
            // old tail links forward to the new slot
            nwe                                  = 1'b1;
            nwr_addr                             = tail_ff[SLOT_W-1:0];
            nwr_data                             = work_slot_ff;
            tail_in                              = work_slot_ff;
            in_use_in[work_slot_ff[SLOT_W-1:0]]  = 1'b1;
            rsp_slot_in                          = work_slot_ff;
         end else begin
            // successor links back to the predecessor
            if (!was_tail_ff && (link_n_ff != SLOT_NONE)) begin
               pwe      = 1'b1;
               pwr_addr = link_n_ff[SLOT_W-1:0];
               pwr_data = link_p_ff;
            end
         end
      end

      if (nwe) begin
         next_vld_in[nwr_addr] = 1'b1;
      end
      if (pwe) begin
         prev_vld_in[pwr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (nwe) begin
         next_mem[nwr_addr] <= nwr_data;
      end
      if (pwe) begin
         prev_mem[pwr_addr] <= pwr_data;
      end
      if (cmd.load) begin
         rd_next_raw_ff <= next_mem[rd_addr_in];
         rd_prev_raw_ff <= prev_mem[rd_addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_vld_ff   <= '0;
         prev_vld_ff   <= '0;
         in_use_ff     <= NUM_SLOTS'(1);
         free_head_ff  <= id_type'(1);
         tail_ff       <= '0;
         count_ff      <= id_type'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         next_vld_ff   <= next_vld_in;
         prev_vld_ff   <= prev_vld_in;
         in_use_ff     <= in_use_in;
         free_head_ff  <= free_head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= op_type'(req_opcode);
         idx_ff     <= req_slot_index;
         rd_addr_ff <= rd_addr_in;
         rd_nvld_ff <= next_vld_ff[rd_addr_in];
         rd_pvld_ff <= prev_vld_ff[rd_addr_in];
      end
      link_p_ff    <= link_p_in;
      link_n_ff    <= link_n_in;
      work_slot_ff <= work_slot_in;
      was_tail_ff  <= was_tail_in;
      if (rsp_load) begin
         rsp_slot_ff   <= rsp_slot_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_used_count  = rsp_count_ff;

endmodule
